>>> rtl/sef_pkg.sv
// Shared types and constants for the substring erase filter.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package sef_pkg;

  localparam int BYTE_W    = 8;
  localparam int SLOT_N    = 8;   // widest window and largest burst of results
  localparam int CNT_W     = 4;   // holds 0 .. SLOT_N
  localparam int IDX_W     = 3;   // selects one of SLOT_N slots
  localparam int PAT_W     = 64;
  localparam int LEN_W     = 4;
  localparam int CFG_IDX_W = 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_BYTES  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 1'b1;

  // One accepted byte's worth of output: the first count slots of bytes are
  // emitted; count zero with last set means a bare end marker.
  typedef struct packed {
    logic [SLOT_N-1:0][BYTE_W-1:0] bytes;
    logic [CNT_W-1:0]              count;
    logic                          last;
  } job_t;

endpackage
`default_nettype wire

>>> rtl/sef_window.sv
// Match window and configuration registers of the substring erase filter.
// Builds one output job per accepted byte; depends on sef_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sef_window #(
  parameter int MAX_PATTERN = 8
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 cfg_we_i,
  input  wire  [sef_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire  [sef_pkg::PAT_W-1:0]           cfg_data_i,
  input  wire                                 accept_i,
  input  wire  [sef_pkg::BYTE_W-1:0]          in_byte_i,
  input  wire                                 in_last_i,
  output sef_pkg::job_t                       job_o,
  output logic                                job_load_o,
  output logic [sef_pkg::CNT_W-1:0]           fill_o
);
  import sef_pkg::*;

  logic [PAT_W-1:0]  pattern_q;
  logic [LEN_W-1:0]  length_q;
  logic [CNT_W-1:0]  fill_q, fill_d;
  logic [BYTE_W-1:0] held_q [MAX_PATTERN];
  logic [BYTE_W-1:0] held_d [MAX_PATTERN];

  logic [CNT_W-1:0]              eff_len, cnt, drop, keep;
  logic [SLOT_N-1:0][BYTE_W-1:0] win;
  logic [SLOT_N-1:0][BYTE_W-1:0] tail;
  logic                          full, mismatch, matched;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q <= '0;
      length_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_PATTERN_BYTES:  pattern_q <= cfg_data_i;
        CFG_PATTERN_LENGTH: length_q  <= cfg_data_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    eff_len = (length_q > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : length_q;
    cnt     = fill_q + CNT_W'(1);

    // held bytes followed by the new one
    win = '0;
    for (int j = 0; j < MAX_PATTERN; j++) begin
      win[j] = (j < int'(fill_q)) ? held_q[j] : in_byte_i;
    end

    // bytes beyond the pattern length leave at once
    drop = (cnt > eff_len) ? cnt - eff_len : '0;
    full = (eff_len != '0) && (cnt >= eff_len);

    tail = '0;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      for (int m = 0; m < MAX_PATTERN; m++) begin
        if (m == i + int'(drop)) tail[i] = win[m];
      end
    end

    mismatch = 1'b0;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if (i < int'(eff_len) && tail[i] != pattern_q[i*BYTE_W +: BYTE_W]) mismatch = 1'b1;
    end
    matched = full && !mismatch;

    if (matched)        keep = drop;
    else if (in_last_i) keep = cnt;
    else if (full)      keep = drop + CNT_W'(1);
    else                keep = drop;

    fill_d = (matched || in_last_i) ? '0 : cnt - keep;

    for (int j = 0; j < MAX_PATTERN; j++) begin
      held_d[j] = '0;
      for (int m = 0; m < MAX_PATTERN; m++) begin
        if (m == j + int'(keep)) held_d[j] = win[m];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (accept_i) begin
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      for (int j = 0; j < MAX_PATTERN; j++) held_q[j] <= held_d[j];
    end
  end

  assign job_o.bytes = win;
  assign job_o.count = keep;
  assign job_o.last  = in_last_i;
  assign job_load_o  = accept_i && ((keep != '0) || in_last_i);
  assign fill_o      = fill_q;

endmodule
`default_nettype wire

>>> rtl/sef_emit.sv
// Result sequencer of the substring erase filter: a job register drained one
// result per unstalled cycle into an output register. Depends on sef_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sef_emit (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  sef_pkg::job_t                job_i,
  input  wire                          job_load_i,
  output logic                         busy_o,
  output logic                         out_valid_o,
  input  wire                          out_stall_i,
  output logic [sef_pkg::BYTE_W-1:0]   out_byte_o,
  output logic                         out_present_o,
  output logic                         out_last_o
);
  import sef_pkg::*;

  job_t              job_q;
  logic              job_valid_q;
  logic [IDX_W-1:0]  idx_q;
  logic              out_valid_q, out_present_q, out_last_q;
  logic [BYTE_W-1:0] out_byte_q;

  logic [CNT_W-1:0]  n_items;
  logic              move, final_item;

  assign n_items    = (job_q.count == '0) ? CNT_W'(1) : job_q.count;
  assign move       = job_valid_q && (!out_valid_q || !out_stall_i);
  assign final_item = ({1'b0, idx_q} + CNT_W'(1)) == n_items;
  assign busy_o     = job_valid_q && !(move && final_item);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
      idx_q       <= '0;
    end else if (job_load_i) begin
      job_valid_q <= 1'b1;
      idx_q       <= '0;
    end else if (move && final_item) begin
      job_valid_q <= 1'b0;
    end else if (move) begin
      idx_q <= idx_q + IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_load_i) job_q <= job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (move) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      // zero count is the bare end marker
      out_present_q <= (job_q.count != '0);
      out_byte_q    <= (job_q.count != '0) ? job_q.bytes[idx_q] : '0;
      out_last_q    <= job_q.last && final_item;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = out_byte_q;
  assign out_present_o = out_present_q;
  assign out_last_o    = out_last_q;

endmodule
`default_nettype wire

>>> rtl/substring_erase_filter_unit.sv
// Top level of the substring erase filter.
// Instantiates sef_window and sef_emit; depends on sef_pkg.
//
// Streams a string one byte per request and removes every leftmost,
// non-overlapping occurrence of the programmed pattern (pattern_length bytes,
// first byte in bits 7:0 of pattern_bytes, lengths above MAX_PATTERN act as
// MAX_PATTERN, zero passes bytes through). A byte is taken in every cycle as
// long as each byte yields at most one result and the output does not stall;
// a request with in_last set flushes the held window, up to MAX_PATTERN
// results, one per cycle from the result sequencer while the output does not
// stall, and the input stalls while that burst drains.
// A string that leaves nothing ends with one result with out_present low.
// The first result of a byte passes through the job register and then the
// output register after the byte is accepted; the window compare and update
// are done in the cycle the byte is accepted.
`timescale 1ns / 1ps
`default_nettype none
module substring_erase_filter_unit #(
  parameter int MAX_PATTERN = 8
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 cfg_we_i,
  input  wire  [sef_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire  [sef_pkg::PAT_W-1:0]           cfg_data_i,
  input  wire                                 in_valid_i,
  output logic                                in_stall_o,
  input  wire  [sef_pkg::BYTE_W-1:0]          in_byte_i,
  input  wire                                 in_last_i,
  output logic                                out_valid_o,
  input  wire                                 out_stall_i,
  output logic [sef_pkg::BYTE_W-1:0]          out_byte_o,
  output logic                                out_present_o,
  output logic                                out_last_o
);
  import sef_pkg::*;

  job_t             job;
  logic             job_load, emit_busy, accept;
  logic [CNT_W-1:0] win_fill;

  assign in_stall_o = emit_busy;
  assign accept     = in_valid_i && !emit_busy;

  sef_window #(
    .MAX_PATTERN(MAX_PATTERN)
  ) u_window (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .accept_i   (accept),
    .in_byte_i  (in_byte_i),
    .in_last_i  (in_last_i),
    .job_o      (job),
    .job_load_o (job_load),
    .fill_o     (win_fill)
  );

  sef_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_i        (job),
    .job_load_i   (job_load),
    .busy_o       (emit_busy),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_o   (out_byte_o),
    .out_present_o(out_present_o),
    .out_last_o   (out_last_o)
  );

`ifndef SYNTHESIS
  // a job may only enter a free sequencer
  assert property (@(posedge clk_i) disable iff (!rst_ni) job_load |-> !emit_busy)
    else $error("job loaded while sequencer busy");

  // a string's end always empties the window
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_last_i |=> win_fill == '0)
    else $error("window not empty after last byte");

  // a bare marker carries a zero byte and closes the string
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_present_o |-> out_byte_o == '0 && out_last_o)
    else $error("malformed end marker");
`endif

endmodule
`default_nettype wire
